>>> rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions. Each macro expects i_clk and the
// active-low synchronous reset i_rst_n in scope.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define C128_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define C128_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define C128_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/c128_pkg.sv
// -----------------------------------------------------------------------------
// c128_pkg
// Widths, codes, register map, bar pattern table and small arithmetic helpers
// shared by the Code 128 symbol encoder.
// -----------------------------------------------------------------------------
package c128_pkg;

    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned SYM_W   = 7;
    localparam int unsigned BARS_W  = 21;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned SET_W   = 2;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CHK_W   = 7;
    localparam int unsigned PROD_W  = 2 * CHK_W;
    localparam int unsigned MODIN_W = PROD_W + 1;
    localparam int unsigned SLOTS   = 5;
    localparam int unsigned APB_AW  = 4;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned NUM_SYMS = 107;

    // Code sets.
    localparam logic [SET_W-1:0] SET_A = 2'd0;
    localparam logic [SET_W-1:0] SET_B = 2'd1;
    localparam logic [SET_W-1:0] SET_C = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_CHAR   = 2'd1;
    localparam logic [STAT_W-1:0] ST_ODD_DIGITS = 2'd2;

    // Register indexes (byte address / 4).
    localparam logic [APB_AW-3:0] REG_CODE_SET  = 2'd0;
    localparam logic [APB_AW-3:0] REG_EAN_MODE  = 2'd1;
    localparam logic [APB_AW-3:0] REG_CHECK_EN  = 2'd2;

    // Special symbol values.
    localparam logic [SYM_W-1:0] SYM_FNC1    = 7'd102;
    localparam logic [SYM_W-1:0] SYM_START_A = 7'd103;
    localparam logic [SYM_W-1:0] SYM_STOP    = 7'd106;
    localparam logic [SYM_W-1:0] SYM_MAX     = 7'd106;

    localparam logic [CHK_W-1:0] CHK_MOD        = 7'd103;
    localparam logic [CHK_W-1:0] CHK_MAX_WEIGHT = 7'd102;

    // Slot order inside one character's burst of results.
    localparam int unsigned SLOT_START = 0;
    localparam int unsigned SLOT_FNC1  = 1;
    localparam int unsigned SLOT_DATA  = 2;
    localparam int unsigned SLOT_CHECK = 3;
    localparam int unsigned SLOT_STOP  = 4;

    typedef struct packed {
        logic [SET_W-1:0] code_set;
        logic             ean_mode;
        logic             check_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{code_set: SET_B, ean_mode: 1'b0, check_enable: 1'b1};

    // Module widths, one octal digit per element, first element in the low digit.
    localparam logic [BARS_W-1:0] C128_BARS [NUM_SYMS] = '{
        21'o0222212, 21'o0221222, 21'o0122222, 21'o0322121, 21'o0223121, 21'o0222131,
        21'o0312221, 21'o0213221, 21'o0212231, 21'o0312122, 21'o0213122, 21'o0212132,
        21'o0232211, 21'o0231221, 21'o0132221, 21'o0222311, 21'o0221321, 21'o0122321,
        21'o0112322, 21'o0231122, 21'o0132122, 21'o0212312, 21'o0211322, 21'o0131213,
        21'o0222113, 21'o0221123, 21'o0122123, 21'o0212213, 21'o0211223, 21'o0112223,
        21'o0321212, 21'o0123212, 21'o0121232, 21'o0323111, 21'o0321131, 21'o0123131,
        21'o0313211, 21'o0311231, 21'o0113231, 21'o0313112, 21'o0311132, 21'o0113132,
        21'o0331211, 21'o0133211, 21'o0131231, 21'o0321311, 21'o0123311, 21'o0121331,
        21'o0121313, 21'o0133112, 21'o0131132, 21'o0311312, 21'o0113312, 21'o0131312,
        21'o0321113, 21'o0123113, 21'o0121133, 21'o0311213, 21'o0113213, 21'o0111233,
        21'o0111413, 21'o0114122, 21'o0111134, 21'o0422111, 21'o0224111, 21'o0421121,
        21'o0124121, 21'o0221141, 21'o0122141, 21'o0412211, 21'o0214211, 21'o0411221,
        21'o0114221, 21'o0211241, 21'o0112241, 21'o0112142, 21'o0411122, 21'o0111314,
        21'o0211142, 21'o0111431, 21'o0242111, 21'o0241121, 21'o0142121, 21'o0212411,
        21'o0211421, 21'o0112421, 21'o0212114, 21'o0211124, 21'o0112124, 21'o0141212,
        21'o0121412, 21'o0121214, 21'o0341111, 21'o0143111, 21'o0141131, 21'o0311411,
        21'o0113411, 21'o0311114, 21'o0113114, 21'o0141311, 21'o0131411, 21'o0141113,
        21'o0131114, 21'o0214112, 21'o0412112, 21'o0232112, 21'o2111332
    };

    function automatic logic [BARS_W-1:0] c128_bars(input logic [SYM_W-1:0] sym);
        logic [BARS_W-1:0] res;
        res = '0;
        if (sym <= SYM_MAX) begin
            res = C128_BARS[sym];
        end
        return res;
    endfunction

    // Reduction modulo 103 by folding: 128 is 25 modulo 103, so the upper bits
    // fold down with a constant multiply until a final conditional subtract.
    function automatic logic [CHK_W-1:0] c128_mod103(input logic [MODIN_W-1:0] x);
        logic [11:0] t1;
        logic [9:0]  t2;
        logic [7:0]  t3;
        logic [7:0]  res;
        t1  = 12'(x[MODIN_W-1:7]) * 12'd25 + 12'(x[6:0]);
        t2  = 10'(t1[11:7]) * 10'd25 + 10'(t1[6:0]);
        t3  = 8'(t2[9:7]) * 8'd25 + 8'(t2[6:0]);
        res = t3;
        if (t3 >= 8'(2 * 103)) begin
            res = t3 - 8'(2 * 103);
        end else if (t3 >= 8'(CHK_MOD)) begin
            res = t3 - 8'(CHK_MOD);
        end
        return res[CHK_W-1:0];
    endfunction

endpackage

>>> rtl/c128_cfg.sv
// -----------------------------------------------------------------------------
// c128_cfg
// APB register file holding the code set, EAN mode and check enable settings.
// -----------------------------------------------------------------------------
module c128_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [c128_pkg::APB_AW-1:0] paddr,
    input  logic [c128_pkg::APB_DW-1:0] pwdata,
    output logic [c128_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output c128_pkg::t_cfg              o_cfg
);
    import c128_pkg::*;

    t_cfg              r_cfg;
    logic [APB_AW-3:0] reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CODE_SET: r_cfg.code_set     <= pwdata[SET_W-1:0];
                REG_EAN_MODE: r_cfg.ean_mode     <= pwdata[0];
                REG_CHECK_EN: r_cfg.check_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_CODE_SET: prdata[SET_W-1:0] = r_cfg.code_set;
            REG_EAN_MODE: prdata[0]         = r_cfg.ean_mode;
            REG_CHECK_EN: prdata[0]         = r_cfg.check_enable;
            default: ;
        endcase
    end

endmodule

>>> rtl/code128_symbol_encoder.sv
// -----------------------------------------------------------------------------
// code128_symbol_encoder
// Encodes message characters in a fixed code set into Code 128 symbols with
// their bar and space widths, start, FNC1, check and stop symbols included.
// -----------------------------------------------------------------------------
// Each accepted character is encoded into a burst of up to five result
// symbols (start, FNC1, data, check, stop) held in a slot register, and the
// slots drain through a single output register at one symbol per cycle while
// i_out_ready is high. A new character is taken only when the slot register is
// empty or its last symbol is moving out; a held set C digit or a character
// dropped after an error yields no symbol, and only the first and last
// characters of a message add start, FNC1, check and stop symbols. Results
// pass through the slot register and then the output register. The running
// checksum uses one 7x7 multiply and a fold-based modulo 103 reduction.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module code128_symbol_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [c128_pkg::APB_AW-1:0] paddr,
    input  logic [c128_pkg::APB_DW-1:0] pwdata,
    output logic [c128_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    // Character input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [c128_pkg::CHAR_W-1:0] i_character,
    input  logic                        i_last_char,
    // Symbol output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [c128_pkg::BARS_W-1:0] o_bar_widths,
    output logic [c128_pkg::SYM_W-1:0]  o_symbol_value,
    output logic [c128_pkg::STAT_W-1:0] o_status,
    output logic                        o_last_symbol
);
    import c128_pkg::*;

    t_cfg cfg;

    c128_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Message state
    logic [CHK_W-1:0]   r_sum;
    logic [CHK_W-1:0]   r_weight;
    logic               r_started;
    logic [DIGIT_W-1:0] r_pend_digit;
    logic               r_pend_valid;
    logic               r_failed;

    // Slot register: one character's results
    logic [SLOTS-1:0]   r_mask;
    logic [SYM_W-1:0]   r_sym [SLOTS];
    logic [STAT_W-1:0]  r_slot_status;
    logic [SLOTS-1:0]   n_mask;
    logic [SYM_W-1:0]   n_sym [SLOTS];
    logic [STAT_W-1:0]  n_slot_status;

    // Output register
    logic               r_out_valid;
    logic [BARS_W-1:0]  r_out_bars;
    logic [SYM_W-1:0]   r_out_sym;
    logic [STAT_W-1:0]  r_out_status;
    logic               r_out_last;

    // Encode path
    logic [STAT_W-1:0]  err;
    logic [SYM_W-1:0]   val;
    logic               have;
    logic               pend_load;
    logic               pend_clear;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [SYM_W-1:0]   pair;
    logic               fnc;
    logic [SYM_W-1:0]   start_sym;
    logic [CHK_W-1:0]   start_rem;
    logic [CHK_W-1:0]   fnc_sum;
    logic [CHK_W-1:0]   base_sum;
    logic [CHK_W-1:0]   base_w;
    logic [PROD_W-1:0]  prod;
    logic [MODIN_W-1:0] sum_x;
    logic [CHK_W-1:0]   sum_new;
    logic [CHK_W-1:0]   w_next;

    // Handshake
    logic [SLOTS-1:0]   slot_low;
    logic [SLOTS-1:0]   slot_rest;
    logic               slot_has;
    logic               slot_single;
    logic               slot_move;
    logic [SYM_W-1:0]   sel_sym;
    logic               out_take;
    logic               out_free;
    logic               in_fire;

    // Assertion terms
    logic               out_err;
    logic               out_blank;
    logic               chk_in_range;
    logic               pend_ok;
    logic               last_fire;
    logic               msg_idle;

    // Character classification per code set
    always_comb begin
        err        = ST_OK;
        val        = '0;
        have       = 1'b0;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        is_digit   = (i_character >= 7'd48) && (i_character <= 7'd57);
        digit      = i_character[DIGIT_W-1:0];
        pair       = (SYM_W'(r_pend_digit) << 3) + (SYM_W'(r_pend_digit) << 1)
                     + SYM_W'(digit);
        priority if (r_pend_valid && (cfg.code_set != SET_C)) begin
            // A held digit cannot be completed outside set C.
            err = ST_ODD_DIGITS;
        end else if (cfg.code_set == SET_A) begin
            if (i_character < 7'd32) begin
                val  = i_character + 7'd64;
                have = 1'b1;
            end else if (i_character < 7'd96) begin
                val  = i_character - 7'd32;
                have = 1'b1;
            end else begin
                err = ST_BAD_CHAR;
            end
        end else if (cfg.code_set == SET_B) begin
            if (i_character >= 7'd32) begin
                val  = i_character - 7'd32;
                have = 1'b1;
            end else begin
                err = ST_BAD_CHAR;
            end
        end else if (cfg.code_set == SET_C) begin
            if (!is_digit) begin
                err = ST_BAD_CHAR;
            end else if (r_pend_valid) begin
                val        = pair;
                have       = 1'b1;
                pend_clear = 1'b1;
            end else if (i_last_char) begin
                err = ST_ODD_DIGITS;
            end else begin
                pend_load = 1'b1;
            end
        end else begin
            err = ST_BAD_CHAR;
        end
    end

    // Checksum: start value weight 1, then FNC1 and data with rising weights.
    always_comb begin
        fnc       = !r_started && (cfg.code_set == SET_C) && cfg.ean_mode;
        start_sym = SYM_START_A + SYM_W'(cfg.code_set);
        start_rem = CHK_W'(cfg.code_set);
        fnc_sum   = c128_mod103(MODIN_W'(start_rem) + MODIN_W'(SYM_FNC1));
        if (r_started) begin
            base_sum = r_sum;
            base_w   = r_weight;
        end else if (fnc) begin
            base_sum = fnc_sum;
            base_w   = 7'd2;
        end else begin
            base_sum = start_rem;
            base_w   = 7'd1;
        end
        prod  = PROD_W'(val) * PROD_W'(base_w);
        sum_x = MODIN_W'(prod) + MODIN_W'(base_sum);
        if (have) begin
            sum_new = c128_mod103(sum_x);
            w_next  = (base_w == CHK_MAX_WEIGHT) ? '0 : base_w + 7'd1;
        end else begin
            sum_new = base_sum;
            w_next  = base_w;
        end
    end

    // Build the slot contents for this character.
    always_comb begin
        n_sym[SLOT_START] = start_sym;
        n_sym[SLOT_FNC1]  = SYM_FNC1;
        n_sym[SLOT_DATA]  = val;
        n_sym[SLOT_CHECK] = sum_new;
        n_sym[SLOT_STOP]  = SYM_STOP;
        n_mask            = '0;
        n_slot_status     = ST_OK;
        if (r_failed) begin
            n_mask = '0;
        end else if (err != ST_OK) begin
            n_mask[SLOT_START] = 1'b1;
            n_slot_status      = err;
        end else begin
            n_mask[SLOT_START] = !r_started;
            n_mask[SLOT_FNC1]  = fnc;
            n_mask[SLOT_DATA]  = have;
            n_mask[SLOT_CHECK] = i_last_char && cfg.check_enable;
            n_mask[SLOT_STOP]  = i_last_char;
        end
    end

    // The slot register drains lowest slot first into the output register.
    assign slot_low    = r_mask & (~r_mask + SLOTS'(1));
    assign slot_rest   = r_mask & ~slot_low;
    assign slot_has    = |r_mask;
    assign slot_single = (slot_rest == '0);
    assign out_take    = r_out_valid & i_out_ready;
    assign out_free    = !r_out_valid | out_take;
    assign slot_move   = slot_has & out_free;
    assign o_in_ready  = !slot_has | (slot_move & slot_single);
    assign in_fire     = i_in_valid & o_in_ready;

    always_comb begin
        sel_sym = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_low[i]) begin
                sel_sym = sel_sym | r_sym[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (in_fire) begin
            r_mask <= n_mask;
        end else if (slot_move) begin
            r_mask <= slot_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sym         <= n_sym;
            r_slot_status <= n_slot_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_weight     <= 7'd1;
            r_started    <= 1'b0;
            r_pend_digit <= '0;
            r_pend_valid <= 1'b0;
            r_failed     <= 1'b0;
        end else if (in_fire) begin
            if (i_last_char) begin
                // Any last character, good or bad, closes the message.
                r_sum        <= '0;
                r_weight     <= 7'd1;
                r_started    <= 1'b0;
                r_pend_digit <= '0;
                r_pend_valid <= 1'b0;
                r_failed     <= 1'b0;
            end else if (r_failed) begin
                r_failed <= 1'b1;
            end else if (err != ST_OK) begin
                r_failed <= 1'b1;
            end else begin
                r_started <= 1'b1;
                r_sum     <= sum_new;
                r_weight  <= w_next;
                if (pend_load) begin
                    r_pend_digit <= digit;
                    r_pend_valid <= 1'b1;
                end else if (pend_clear) begin
                    r_pend_digit <= '0;
                    r_pend_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_move) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_move) begin
            r_out_status <= r_slot_status;
            r_out_last   <= slot_single;
            if (r_slot_status != ST_OK) begin
                r_out_sym  <= '0;
                r_out_bars <= '0;
            end else begin
                r_out_sym  <= sel_sym;
                r_out_bars <= c128_bars(sel_sym);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bar_widths   = r_out_bars;
    assign o_symbol_value = r_out_sym;
    assign o_status       = r_out_status;
    assign o_last_symbol  = r_out_last;

    assign out_err      = o_out_valid && (o_status != ST_OK);
    assign out_blank    = o_last_symbol && (o_symbol_value == '0) && (o_bar_widths == '0);
    assign chk_in_range = (r_sum < CHK_MOD) && (r_weight < CHK_MOD);
    assign pend_ok      = r_started && (r_pend_digit <= 4'd9);
    assign last_fire    = in_fire && i_last_char;
    assign msg_idle     = !r_started && !r_failed && !r_pend_valid;

    `C128_ASSERT_IMPL(a_err_alone, out_err, out_blank, "error result is not a lone empty symbol")
    `C128_ASSERT_ALWAYS(a_chk_range, chk_in_range, "checksum state out of range")
    `C128_ASSERT_IMPL(a_pend_started, r_pend_valid, pend_ok, "held digit outside a message")
    `C128_ASSERT_NEXT(a_last_clears, last_fire, msg_idle, "message state not cleared")

endmodule
